// ----- sv/itrs_pkg.sv -----
// Package for the integer to Roman symbol converter: types, codes and symbol tables.
package itrs_pkg;

  localparam int BIN_W   = 20;
  localparam int DIGITS  = 7;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = 5;
  localparam int LVL_W   = 3;

  localparam logic [BIN_W-1:0] MAX_VALUE = BIN_W'(1000000);

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [3:0] SYM_I   = 4'd0;
  localparam logic [3:0] SYM_V   = 4'd1;
  localparam logic [3:0] SYM_X   = 4'd2;
  localparam logic [3:0] SYM_L   = 4'd3;
  localparam logic [3:0] SYM_C   = 4'd4;
  localparam logic [3:0] SYM_D   = 4'd5;
  localparam logic [3:0] SYM_M   = 4'd6;
  localparam logic [3:0] SYM_OV  = 4'd7;
  localparam logic [3:0] SYM_OX  = 4'd8;
  localparam logic [3:0] SYM_OL  = 4'd9;
  localparam logic [3:0] SYM_OC  = 4'd10;
  localparam logic [3:0] SYM_OD  = 4'd11;
  localparam logic [3:0] SYM_OM  = 4'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_ONE,
    K_FIVE,
    K_TEN
  } kind_t;

  // Symbol for a digit position, level 0 is the millions.
  function automatic logic [3:0] level_sym(input logic [LVL_W-1:0] lvl, input kind_t kind);
    logic [3:0] one, five, ten;
    case (lvl)
      3'd0: begin one = SYM_OM; five = SYM_OM; ten = SYM_OM; end
      3'd1: begin one = SYM_OC; five = SYM_OD; ten = SYM_OM; end
      3'd2: begin one = SYM_OX; five = SYM_OL; ten = SYM_OC; end
      3'd3: begin one = SYM_M;  five = SYM_OV; ten = SYM_OX; end
      3'd4: begin one = SYM_C;  five = SYM_D;  ten = SYM_M;  end
      3'd5: begin one = SYM_X;  five = SYM_L;  ten = SYM_C;  end
      3'd6: begin one = SYM_I;  five = SYM_V;  ten = SYM_X;  end
      default: begin one = SYM_I; five = SYM_I; ten = SYM_I; end
    endcase
    case (kind)
      K_FIVE:  return five;
      K_TEN:   return ten;
      default: return one;
    endcase
  endfunction

  // Index of the final symbol in a nonzero digit's group.
  function automatic logic [1:0] final_pos(input logic [3:0] d);
    logic [1:0] p;
    case (d)
      4'd1: p = 2'd0;
      4'd2: p = 2'd1;
      4'd3: p = 2'd2;
      4'd4: p = 2'd1;
      4'd5: p = 2'd0;
      4'd6: p = 2'd1;
      4'd7: p = 2'd2;
      4'd8: p = 2'd3;
      4'd9: p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  // Which of unit, five or ten sits at position p of digit d.
  function automatic kind_t sym_kind(input logic [3:0] d, input logic [1:0] p);
    kind_t k;
    case (d)
      4'd4: k = (p == 2'd0) ? K_ONE : K_FIVE;
      4'd5: k = K_FIVE;
      4'd6, 4'd7, 4'd8: k = (p == 2'd0) ? K_FIVE : K_ONE;
      4'd9: k = (p == 2'd0) ? K_ONE : K_TEN;
      default: k = K_ONE;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/integer_to_roman_symbols.sv -----
// Top level: converts a signed integer into a run of Roman symbol codes.
// Out-of-range or zero input: one result in the cycle after the start transfer, never busy.
// Otherwise bit-serial binary to BCD conversion, then one symbol per cycle, with a gap for
// each zero digit ahead of the last nonzero one; busy until the last symbol, no new
// transfer is taken while busy, and results cannot be stalled.
// Reset (synchronous, rst_n low) returns to idle and drops the strobe.
module integer_to_roman_symbols (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [20:0]  in_number,
  output logic                out_strobe,
  output logic [3:0]          out_symbol,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import itrs_pkg::*;

  state_t             state_r, state_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [1:0]         rep_r, rep_nxt;
  logic               strobe_r, strobe_nxt;
  logic [3:0]         symbol_r, symbol_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               last_r, last_nxt;
  logic [3:0]         digit;
  logic               rest_zero;

  assign digit     = bcd_r[BCD_W-1 -: 4];
  assign rest_zero = (bcd_r[BCD_W-5:0] == '0);

  // add-3 correction per BCD digit before each shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    cnt_nxt    = cnt_r;
    lvl_nxt    = lvl_r;
    rep_nxt    = rep_r;
    strobe_nxt = 1'b0;
    symbol_nxt = symbol_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_number[20] || (in_number[BIN_W-1:0] > MAX_VALUE)) begin
            strobe_nxt = 1'b1;
            symbol_nxt = SYM_I;
            status_nxt = STAT_RANGE;
            last_nxt   = 1'b1;
          end else if (in_number[BIN_W-1:0] == '0) begin
            strobe_nxt = 1'b1;
            symbol_nxt = SYM_I;
            status_nxt = STAT_EMPTY;
            last_nxt   = 1'b1;
          end else begin
            bin_nxt   = in_number[BIN_W-1:0];
            bcd_nxt   = '0;
            cnt_nxt   = CNT_W'(BIN_W);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          lvl_nxt   = '0;
          rep_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (digit == 4'd0) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          lvl_nxt = lvl_r + 1'b1;
          rep_nxt = '0;
        end else begin
          strobe_nxt = 1'b1;
          symbol_nxt = level_sym(lvl_r, sym_kind(digit, rep_r));
          status_nxt = STAT_OK;
          last_nxt   = 1'b0;
          if (rep_r == final_pos(digit)) begin
            bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
            lvl_nxt = lvl_r + 1'b1;
            rep_nxt = '0;
            if (rest_zero) begin
              last_nxt  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            rep_nxt = rep_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    cnt_r    <= cnt_nxt;
    lvl_r    <= lvl_nxt;
    rep_r    <= rep_nxt;
    symbol_r <= symbol_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_symbol = symbol_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

// ----- bench/tb_integer_to_roman_symbols.sv -----
// Testbench for integer_to_roman_symbols: directed table plus random numbers vs a predictor.
`timescale 1ns / 100ps

module tb_integer_to_roman_symbols;
  import itrs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 82;
  localparam int ROW_COUNT = 24;

  typedef struct packed {
    logic [3:0] symbol;
    logic [1:0] status;
    logic       last;
  } numeral_t;

  typedef struct packed {
    logic signed [20:0] number;
    logic               typed;
    numeral_t           result;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [20:0] in_number;
  logic               out_strobe;
  logic [3:0]         out_symbol;
  logic [1:0]         out_status;
  logic               out_last;

  logic               row_typed;
  numeral_t           row_result;
  numeral_t           pending_symbols[$];
  int                 mismatches = 0;

  // typed rows carry their single expected result, the rest use the predictor
  localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{21'sd0,        1'b1, '{SYM_I,  STAT_EMPTY, 1'b1}},
    '{21'sd1,        1'b1, '{SYM_I,  STAT_OK,    1'b1}},
    '{21'sd1000000,  1'b1, '{SYM_OM, STAT_OK,    1'b1}},
    '{21'sd1000001,  1'b1, '{SYM_I,  STAT_RANGE, 1'b1}},
    '{21'sd1048575,  1'b1, '{SYM_I,  STAT_RANGE, 1'b1}},
    '{-21'sd1,       1'b1, '{SYM_I,  STAT_RANGE, 1'b1}},
    '{-21'sd1048576, 1'b1, '{SYM_I,  STAT_RANGE, 1'b1}},
    '{21'sd5,        1'b1, '{SYM_V,  STAT_OK,    1'b1}},
    '{21'sd4,        1'b0, '0},
    '{21'sd9,        1'b0, '0},
    '{21'sd10,       1'b0, '0},
    '{21'sd40,       1'b0, '0},
    '{21'sd90,       1'b0, '0},
    '{21'sd400,      1'b0, '0},
    '{21'sd900,      1'b0, '0},
    '{21'sd3999,     1'b0, '0},
    '{21'sd4000,     1'b0, '0},
    '{21'sd3888,     1'b0, '0},
    '{21'sd44444,    1'b0, '0},
    '{21'sd100000,   1'b0, '0},
    '{21'sd500000,   1'b0, '0},
    '{21'sd494949,   1'b0, '0},
    '{21'sd999999,   1'b0, '0},
    '{21'sd888888,   1'b0, '0}
  };

  integer_to_roman_symbols dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_number  (in_number),
    .out_strobe (out_strobe),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void queue_numeral(input logic signed [20:0] n);
    numeral_t   run[$];
    numeral_t   sym;
    int         v;
    int         w;
    int         d;
    logic [3:0] one_s, five_s, ten_s;
    if (n < 0 || n > int'(MAX_VALUE)) begin
      pending_symbols.push_back('{SYM_I, STAT_RANGE, 1'b1});
      return;
    end
    if (n == 0) begin
      pending_symbols.push_back('{SYM_I, STAT_EMPTY, 1'b1});
      return;
    end
    v = n;
    w = 1000000;
    for (int lvl = 0; lvl < DIGITS; lvl++) begin
      case (lvl)
        0: begin one_s = SYM_OM; five_s = SYM_OM; ten_s = SYM_OM; end
        1: begin one_s = SYM_OC; five_s = SYM_OD; ten_s = SYM_OM; end
        2: begin one_s = SYM_OX; five_s = SYM_OL; ten_s = SYM_OC; end
        3: begin one_s = SYM_M;  five_s = SYM_OV; ten_s = SYM_OX; end
        4: begin one_s = SYM_C;  five_s = SYM_D;  ten_s = SYM_M;  end
        5: begin one_s = SYM_X;  five_s = SYM_L;  ten_s = SYM_C;  end
        default: begin one_s = SYM_I; five_s = SYM_V; ten_s = SYM_X; end
      endcase
      d = v / w;
      v = v - d * w;
      w = w / 10;
      sym.status = STAT_OK;
      sym.last = 1'b0;
      if (d == 4 || d == 9) begin
        sym.symbol = one_s;
        run.push_back(sym);
        sym.symbol = (d == 4) ? five_s : ten_s;
        run.push_back(sym);
      end else begin
        if (d >= 5) begin
          sym.symbol = five_s;
          run.push_back(sym);
        end
        sym.symbol = one_s;
        for (int j = 0; j < d % 5; j++) run.push_back(sym);
      end
    end
    while (run.size() > 24) void'(run.pop_back());
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_symbols.push_back(run[i]);
  endfunction

  always @(posedge clk) begin : result_check
    numeral_t got;
    numeral_t want;
    if (rst_n && out_strobe) begin
      got = '{out_symbol, out_status, out_last};
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %0d status %0d last %0d",
                                  got.symbol, got.status, got.last));
      end else begin
        want = pending_symbols.pop_front();
        if (got.symbol !== want.symbol || got.status !== want.status ||
            got.last !== want.last)
          report_mismatch($sformatf("got symbol %0d status %0d last %0d, want %0d %0d %0d",
                                    got.symbol, got.status, got.last,
                                    want.symbol, want.status, want.last));
      end
    end
    if (rst_n && start && !busy) begin
      if (row_typed) pending_symbols.push_back(row_result);
      else queue_numeral(in_number);
    end
  end

  // called and returns at a falling edge
  task automatic drive_number(input logic signed [20:0] n, input int idle_pct,
                              input logic typed, input numeral_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_number <= 21'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_number <= n;
    row_typed <= typed;
    row_result <= typed_res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                 idle_pct;
    int                 v;
    logic signed [20:0] n;
    rst_n = 1'b0;
    start = 1'b0;
    in_number = '0;
    row_typed = 1'b0;
    row_result = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i])
      drive_number(DIRECTED_ROWS[i].number, 0, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].result);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 55 : 21;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (phase == 1 && k == RANDOM_PER_PHASE / 2) begin
          start <= 1'b0;
          @(negedge clk);
          while (pending_symbols.size() != 0) @(negedge clk);
        end
        case ($urandom_range(9))
          0: n = (k % 2) ? 21'sd0 : 21'sd1000000;
          1: n = 21'($urandom);
          2, 3: n = 21'($urandom_range(1000000, 1));
          4: n = 21'($urandom_range(3999, 1));
          9: n = 21'($urandom_range(1048575, 1000001));
          default: begin
            // digit-built values favor long runs of subtractive groups
            v = 0;
            for (int j = 0; j < 6; j++) begin
              case ($urandom_range(3))
                0: v = v * 10 + 4;
                1: v = v * 10 + 8;
                2: v = v * 10 + 9;
                default: v = v * 10 + $urandom_range(9);
              endcase
            end
            n = 21'((v == 0) ? 1 : v);
          end
        endcase
        drive_number(n, idle_pct, 1'b0, '0);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending_symbols.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_symbols.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
